FILE: hw/rtl/cau_pkg.sv
// shared constants, opcode type and pipeline word structs for the complex alu
// no dependencies; the files that use it refer to it by scoped names
package cau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int QUO_BITS  = WORD_BITS + 1;
    localparam int REM_BITS  = PROD_BITS + 1;
    localparam int NUM_BITS  = PROD_BITS + FRAC_BITS;
    localparam int DIV_STEPS = QUO_BITS;
    localparam int SQ1_STEPS = WORD_BITS;
    localparam int SQ1_TOP   = PROD_BITS - 2;
    localparam int SQ2_BITS  = QUO_BITS + FRAC_BITS - 1;
    localparam int SQ2_TOP   = SQ2_BITS - 2;
    localparam int SQ2_STEPS = SQ2_TOP / 2 + 1;

    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CONJ,
        OP_MAG,
        OP_SQRT,
        OP_EQ
    } op_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] res_re;
        logic [WORD_BITS-1:0] res_im;
        logic                 div_zero;
        logic                 saturated;
        logic                 is_equal;
    } result_t;

    typedef struct packed {
        logic                neg;
        logic                ovf;
        logic [REM_BITS-1:0] rem;
        logic [QUO_BITS-1:0] nq;
    } div_lane_t;

    typedef struct packed {
        op_t                  op;
        result_t              early;
        logic [WORD_BITS-1:0] ar;
        logic                 ai_neg;
        logic [PROD_BITS-1:0] den;
        div_lane_t            dre;
        div_lane_t            dim;
        logic [PROD_BITS-1:0] sqx;
        logic [PROD_BITS-1:0] sqr;
    } sec1_t;

    typedef struct packed {
        op_t                 op;
        result_t             res;
        logic                ai_neg;
        logic [SQ2_BITS-1:0] xr;
        logic [SQ2_BITS-1:0] rr;
        logic [SQ2_BITS-1:0] xi;
        logic [SQ2_BITS-1:0] ri;
    } sec2_t;

endpackage

FILE: hw/rtl/cau_in_if.sv
// operand channel: valid/ready handshake with opcode and two complex values
// depends on nothing
interface cau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;

    modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
    modport sink (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

FILE: hw/rtl/cau_out_if.sv
// result channel: valid/ready handshake with complex result and flags
// depends on nothing
interface cau_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic        div_zero;
    logic        saturated;
    logic        is_equal;

    modport source (output valid, res_re, res_im, div_zero, saturated, is_equal, input ready);
    modport sink (input valid, res_re, res_im, div_zero, saturated, is_equal, output ready);
endinterface

FILE: hw/rtl/cau_front.sv
// front stages: operand capture, products, sums, divide setup and overflow check
// depends on cau_pkg and cau_in_if
module cau_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    cau_in_if.sink         operands,
    output logic           out_v,
    output cau_pkg::sec1_t out_d
);

    localparam int W = cau_pkg::WORD_BITS;
    localparam int P = cau_pkg::PROD_BITS;
    localparam int S = cau_pkg::SUM_BITS;
    localparam int R = cau_pkg::REM_BITS;
    localparam int N = cau_pkg::NUM_BITS;
    localparam int Q = cau_pkg::QUO_BITS;
    localparam int F = cau_pkg::FRAC_BITS;
    localparam logic signed [S-1:0] ROUND_HALF = S'(1) <<< (F - 1);

    function automatic logic [W:0] sat_word(input logic signed [S-1:0] v);
        logic [W:0] res;
        if (v[S-1:W-1] == {(S-W+1){v[S-1]}}) begin
            res = {1'b0, v[W-1:0]};
        end
        else begin
            res = {1'b1, v[S-1] ? cau_pkg::WORD_MIN : cau_pkg::WORD_MAX};
        end
        return res;
    endfunction

    assign operands.ready = adv;

    // stage 0: operand capture
    logic                 s0_v_reg;
    cau_pkg::op_t         s0_op_reg;
    logic signed [W-1:0]  s0_ar_reg, s0_ai_reg, s0_br_reg, s0_bi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_v_reg <= operands.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_op_reg <= cau_pkg::op_t'(operands.op);
            s0_ar_reg <= operands.a_re;
            s0_ai_reg <= operands.a_im;
            s0_br_reg <= operands.b_re;
            s0_bi_reg <= operands.b_im;
        end
    end

    // stage 1: products and the simple ops
    logic signed [W-1:0] sq_x, sq_y;
    logic signed [W:0]   simp_re, simp_im;
    logic                simp_eq;

    always_comb
    begin
        sq_x    = (s0_op_reg == cau_pkg::OP_DIV) ? s0_br_reg : s0_ar_reg;
        sq_y    = (s0_op_reg == cau_pkg::OP_DIV) ? s0_bi_reg : s0_ai_reg;
        simp_re = '0;
        simp_im = '0;
        simp_eq = 1'b0;
        unique case (s0_op_reg)
            cau_pkg::OP_ADD:
            begin
                simp_re = {s0_ar_reg[W-1], s0_ar_reg} + {s0_br_reg[W-1], s0_br_reg};
                simp_im = {s0_ai_reg[W-1], s0_ai_reg} + {s0_bi_reg[W-1], s0_bi_reg};
            end
            cau_pkg::OP_SUB:
            begin
                simp_re = {s0_ar_reg[W-1], s0_ar_reg} - {s0_br_reg[W-1], s0_br_reg};
                simp_im = {s0_ai_reg[W-1], s0_ai_reg} - {s0_bi_reg[W-1], s0_bi_reg};
            end
            cau_pkg::OP_CONJ:
            begin
                simp_re = {s0_ar_reg[W-1], s0_ar_reg};
                simp_im = -{s0_ai_reg[W-1], s0_ai_reg};
            end
            cau_pkg::OP_EQ:
            begin
                simp_eq = (s0_ar_reg == s0_br_reg) && (s0_ai_reg == s0_bi_reg);
            end
            default:
            begin
                simp_eq = 1'b0;
            end
        endcase
    end

    logic                s1_v_reg;
    cau_pkg::op_t        s1_op_reg;
    logic signed [W:0]   s1_simp_re_reg, s1_simp_im_reg;
    logic                s1_eq_reg;
    logic signed [P-1:0] s1_p_rr_reg, s1_p_ii_reg, s1_p_ri_reg, s1_p_ir_reg;
    logic [P-1:0]        s1_s_x_reg, s1_s_y_reg;
    logic [W-1:0]        s1_ar_reg;
    logic                s1_ai_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= s0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg      <= s0_op_reg;
            s1_simp_re_reg <= simp_re;
            s1_simp_im_reg <= simp_im;
            s1_eq_reg      <= simp_eq;
            s1_p_rr_reg    <= s0_ar_reg * s0_br_reg;
            s1_p_ii_reg    <= s0_ai_reg * s0_bi_reg;
            s1_p_ri_reg    <= s0_ar_reg * s0_bi_reg;
            s1_p_ir_reg    <= s0_ai_reg * s0_br_reg;
            s1_s_x_reg     <= sq_x * sq_x;
            s1_s_y_reg     <= sq_y * sq_y;
            s1_ar_reg      <= s0_ar_reg;
            s1_ai_neg_reg  <= s0_ai_reg[W-1];
        end
    end

    // stage 2: multiply rounding and clamp, divide numerators, sum of squares
    logic signed [S-1:0] mr_sum, mi_sum, mr_sh, mi_sh;
    logic [W:0]          mr_sat, mi_sat, sr_sat, si_sat;
    cau_pkg::result_t    early;
    logic signed [R-1:0] nr, ni;
    logic [P-1:0]        sq_sum;

    always_comb
    begin
        mr_sum = S'(s1_p_rr_reg) - S'(s1_p_ii_reg) + ROUND_HALF;
        mi_sum = S'(s1_p_ri_reg) + S'(s1_p_ir_reg) + ROUND_HALF;
        mr_sh  = mr_sum >>> F;
        mi_sh  = mi_sum >>> F;
        mr_sat = sat_word(mr_sh);
        mi_sat = sat_word(mi_sh);
        sr_sat = sat_word(S'(s1_simp_re_reg));
        si_sat = sat_word(S'(s1_simp_im_reg));
        early.div_zero = 1'b0;
        early.is_equal = s1_eq_reg;
        if (s1_op_reg == cau_pkg::OP_MUL)
        begin
            early.res_re    = mr_sat[W-1:0];
            early.res_im    = mi_sat[W-1:0];
            early.saturated = mr_sat[W] | mi_sat[W];
        end
        else
        begin
            early.res_re    = sr_sat[W-1:0];
            early.res_im    = si_sat[W-1:0];
            early.saturated = sr_sat[W] | si_sat[W];
        end
        nr     = R'(s1_p_rr_reg) + R'(s1_p_ii_reg);
        ni     = R'(s1_p_ir_reg) - R'(s1_p_ri_reg);
        sq_sum = s1_s_x_reg + s1_s_y_reg;
    end

    logic                s2_v_reg;
    cau_pkg::op_t        s2_op_reg;
    cau_pkg::result_t    s2_early_reg;
    logic signed [R-1:0] s2_nr_reg, s2_ni_reg;
    logic [P-1:0]        s2_sq_sum_reg;
    logic [W-1:0]        s2_ar_reg;
    logic                s2_ai_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_early_reg  <= early;
            s2_nr_reg     <= nr;
            s2_ni_reg     <= ni;
            s2_sq_sum_reg <= sq_sum;
            s2_ar_reg     <= s1_ar_reg;
            s2_ai_neg_reg <= s1_ai_neg_reg;
        end
    end

    // stage 3: sign and magnitude of the numerators, scaled and half added
    logic [R-1:0] nr_neg, ni_neg;
    logic [P-1:0] mag_r, mag_i;
    logic [N-1:0] num_r, num_i;

    always_comb
    begin
        nr_neg = -s2_nr_reg;
        ni_neg = -s2_ni_reg;
        mag_r  = s2_nr_reg[R-1] ? nr_neg[P-1:0] : s2_nr_reg[P-1:0];
        mag_i  = s2_ni_reg[R-1] ? ni_neg[P-1:0] : s2_ni_reg[P-1:0];
        num_r  = {mag_r, {F{1'b0}}} + N'(s2_sq_sum_reg >> 1);
        num_i  = {mag_i, {F{1'b0}}} + N'(s2_sq_sum_reg >> 1);
    end

    logic             s3_v_reg;
    cau_pkg::op_t     s3_op_reg;
    cau_pkg::result_t s3_early_reg;
    logic [N-1:0]     s3_num_r_reg, s3_num_i_reg;
    logic             s3_neg_r_reg, s3_neg_i_reg;
    logic [P-1:0]     s3_den_reg;
    logic [W-1:0]     s3_ar_reg;
    logic             s3_ai_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_op_reg     <= s2_op_reg;
            s3_early_reg  <= s2_early_reg;
            s3_num_r_reg  <= num_r;
            s3_num_i_reg  <= num_i;
            s3_neg_r_reg  <= s2_nr_reg[R-1];
            s3_neg_i_reg  <= s2_ni_reg[R-1];
            s3_den_reg    <= s2_sq_sum_reg;
            s3_ar_reg     <= s2_ar_reg;
            s3_ai_neg_reg <= s2_ai_neg_reg;
        end
    end

    // stage 4: quotient overflow check, load the divide and root lanes
    cau_pkg::sec1_t sec1;
    logic [R-1:0]   rem_r, rem_i;

    always_comb
    begin
        rem_r          = R'(s3_num_r_reg[N-1:Q]);
        rem_i          = R'(s3_num_i_reg[N-1:Q]);
        sec1.op        = s3_op_reg;
        sec1.early     = s3_early_reg;
        sec1.ar        = s3_ar_reg;
        sec1.ai_neg    = s3_ai_neg_reg;
        sec1.den       = s3_den_reg;
        sec1.dre.neg   = s3_neg_r_reg;
        sec1.dre.ovf   = rem_r >= {1'b0, s3_den_reg};
        sec1.dre.rem   = rem_r;
        sec1.dre.nq    = s3_num_r_reg[Q-1:0];
        sec1.dim.neg   = s3_neg_i_reg;
        sec1.dim.ovf   = rem_i >= {1'b0, s3_den_reg};
        sec1.dim.rem   = rem_i;
        sec1.dim.nq    = s3_num_i_reg[Q-1:0];
        sec1.sqx       = s3_den_reg;
        sec1.sqr       = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v <= 1'b0;
        end
        else if (adv)
        begin
            out_v <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_d <= sec1;
        end
    end

endmodule

FILE: hw/rtl/cau_ds_stage.sv
// one pipeline stage: a restoring divide step on both parts and, while STEP < SQ1_STEPS, one root step
// depends on cau_pkg
module cau_ds_stage #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_v,
    input  cau_pkg::sec1_t in_d,
    output logic           out_v,
    output cau_pkg::sec1_t out_d
);

    localparam int P = cau_pkg::PROD_BITS;
    localparam int R = cau_pkg::REM_BITS;
    localparam int Q = cau_pkg::QUO_BITS;
    localparam logic DO_ROOT = (STEP < cau_pkg::SQ1_STEPS);
    localparam int SHIFT = DO_ROOT ? (cau_pkg::SQ1_TOP - 2 * STEP) : 0;
    localparam logic [P-1:0] ROOT_BIT = P'(1) << SHIFT;

    function automatic cau_pkg::div_lane_t div_step(input cau_pkg::div_lane_t l,
                                                    input logic [P-1:0] den);
        cau_pkg::div_lane_t o;
        logic [R-1:0]       sh;
        logic               ge;
        o     = l;
        sh    = {l.rem[R-2:0], l.nq[Q-1]};
        ge    = sh >= {1'b0, den};
        o.rem = ge ? (sh - {1'b0, den}) : sh;
        o.nq  = {l.nq[Q-2:0], ge};
        return o;
    endfunction

    cau_pkg::sec1_t nxt;
    logic [P-1:0]   trial;

    always_comb
    begin
        nxt     = in_d;
        nxt.dre = div_step(in_d.dre, in_d.den);
        nxt.dim = div_step(in_d.dim, in_d.den);
        trial   = in_d.sqr + ROOT_BIT;
        if (DO_ROOT)
        begin
            if (in_d.sqx >= trial)
            begin
                nxt.sqx = in_d.sqx - trial;
                nxt.sqr = (in_d.sqr >> 1) + ROOT_BIT;
            end
            else
            begin
                nxt.sqr = in_d.sqr >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v <= 1'b0;
        end
        else if (adv)
        begin
            out_v <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_d <= nxt;
        end
    end

endmodule

FILE: hw/rtl/cau_root_stage.sv
// one pipeline stage of the two square roots behind the principal root
// depends on cau_pkg
module cau_root_stage #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_v,
    input  cau_pkg::sec2_t in_d,
    output logic           out_v,
    output cau_pkg::sec2_t out_d
);

    localparam int B = cau_pkg::SQ2_BITS;
    localparam logic [B-1:0] ROOT_BIT = B'(1) << (cau_pkg::SQ2_TOP - 2 * STEP);

    // returns {remainder, root}
    function automatic logic [2*B-1:0] root_step(input logic [B-1:0] x,
                                                 input logic [B-1:0] r);
        logic [B-1:0] trial;
        logic [B-1:0] xo;
        logic [B-1:0] ro;
        trial = r + ROOT_BIT;
        if (x >= trial)
        begin
            xo = x - trial;
            ro = (r >> 1) + ROOT_BIT;
        end
        else
        begin
            xo = x;
            ro = r >> 1;
        end
        return {xo, ro};
    endfunction

    cau_pkg::sec2_t nxt;

    always_comb
    begin
        nxt = in_d;
        {nxt.xr, nxt.rr} = root_step(in_d.xr, in_d.rr);
        {nxt.xi, nxt.ri} = root_step(in_d.xi, in_d.ri);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v <= 1'b0;
        end
        else if (adv)
        begin
            out_v <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_d <= nxt;
        end
    end

endmodule

FILE: hw/rtl/complex_arithmetic_unit_core.sv
// complex alu top level: front stages, divide/magnitude stages, root stages, output queue
// depends on cau_pkg, cau_in_if, cau_out_if, cau_front, cau_ds_stage, cau_root_stage
//
// Usage: operands is a valid/ready channel carrying op, a_re, a_im, b_re, b_im
// (signed Q16.16); results is a valid/ready channel carrying res_re, res_im,
// div_zero, saturated and is_equal. Every accepted word yields exactly one
// result word, in order.
// Throughput: one word per cycle while results are taken.
// Every op takes the same path through the pipeline.
// The word passes 64 registers, the first loaded at the accepting edge: 5 front
// stages, the 33 restoring divide steps (which also carry the 32 steps of the
// magnitude root), one setup stage, 24 steps of the second root for the
// principal square root, one step per stage, and the output queue.
// Stall: a two-entry output queue holds finished words; when it is full the
// whole pipeline holds and operands.ready goes low, so nothing is lost.
// Reset: rst_n clears all valid bits and the queue; the block accepts words
// in the first cycle after reset.
module complex_arithmetic_unit_core (
    input  logic      clk,
    input  logic      rst_n,
    cau_in_if.sink    operands,
    cau_out_if.source results
);

    localparam int W  = cau_pkg::WORD_BITS;
    localparam int Q  = cau_pkg::QUO_BITS;
    localparam int F  = cau_pkg::FRAC_BITS;
    localparam int DS = cau_pkg::DIV_STEPS;
    localparam int RS = cau_pkg::SQ2_STEPS;
    localparam int FIFO_DEPTH = 2;
    localparam logic [Q-1:0] NEG_LIM = Q'(1) << (W - 1);
    localparam logic [Q-1:0] POS_LIM = NEG_LIM - Q'(1);

    // returns {saturated, value}
    function automatic logic [W:0] div_finish(input cau_pkg::div_lane_t l);
        logic [W:0]   res;
        logic [W-1:0] negq;
        negq = -l.nq[W-1:0];
        if (l.neg)
        begin
            if (l.ovf || (l.nq > NEG_LIM))
            begin
                res = {1'b1, cau_pkg::WORD_MIN};
            end
            else
            begin
                res = {1'b0, negq};
            end
        end
        else
        begin
            if (l.ovf || (l.nq > POS_LIM))
            begin
                res = {1'b1, cau_pkg::WORD_MAX};
            end
            else
            begin
                res = {1'b0, l.nq[W-1:0]};
            end
        end
        return res;
    endfunction

    logic adv;
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    cau_pkg::result_t fifo_mem_reg [FIFO_DEPTH];

    assign adv = (count_reg != 2'(FIFO_DEPTH));

    // front
    logic           sec1_v [DS+1];
    cau_pkg::sec1_t sec1_d [DS+1];

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .operands (operands),
        .out_v    (sec1_v[0]),
        .out_d    (sec1_d[0])
    );

    // divide steps with the magnitude root alongside
    for (genvar k = 0; k < DS; k++)
    begin : g_ds
        cau_ds_stage #(.STEP(k)) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .in_v  (sec1_v[k]),
            .in_d  (sec1_d[k]),
            .out_v (sec1_v[k+1]),
            .out_d (sec1_d[k+1])
        );
    end

    // setup stage: finish divide and magnitude, prepare the principal root
    cau_pkg::sec1_t   s1e;
    cau_pkg::sec2_t   mid;
    logic [W-1:0]     mag;
    logic [W:0]       dr, di;
    logic signed [W+1:0] sum_r, sum_i;

    always_comb
    begin
        s1e   = sec1_d[DS];
        mag   = s1e.sqr[W-1:0];
        dr    = div_finish(s1e.dre);
        di    = div_finish(s1e.dim);
        sum_r = $signed({2'b00, mag}) + (W+2)'($signed(s1e.ar));
        sum_i = $signed({2'b00, mag}) - (W+2)'($signed(s1e.ar));
        mid.op     = s1e.op;
        mid.ai_neg = s1e.ai_neg;
        mid.xr     = {sum_r[Q-1:0], {(F-1){1'b0}}};
        mid.xi     = {sum_i[Q-1:0], {(F-1){1'b0}}};
        mid.rr     = '0;
        mid.ri     = '0;
        mid.res    = s1e.early;
        unique case (s1e.op)
            cau_pkg::OP_DIV:
            begin
                if (s1e.den == '0)
                begin
                    mid.res.res_re    = '0;
                    mid.res.res_im    = '0;
                    mid.res.div_zero  = 1'b1;
                    mid.res.saturated = 1'b0;
                end
                else
                begin
                    mid.res.res_re    = dr[W-1:0];
                    mid.res.res_im    = di[W-1:0];
                    mid.res.saturated = dr[W] | di[W];
                end
            end
            cau_pkg::OP_MAG:
            begin
                mid.res.res_re    = mag[W-1] ? cau_pkg::WORD_MAX : mag;
                mid.res.res_im    = '0;
                mid.res.saturated = mag[W-1];
            end
            default:
            begin
                mid.res = s1e.early;
            end
        endcase
    end

    logic           sec2_v [RS+1];
    cau_pkg::sec2_t sec2_d [RS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec2_v[0] <= 1'b0;
        end
        else if (adv)
        begin
            sec2_v[0] <= sec1_v[DS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sec2_d[0] <= mid;
        end
    end

    for (genvar k = 0; k < RS; k++)
    begin : g_root
        cau_root_stage #(.STEP(k)) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .in_v  (sec2_v[k]),
            .in_d  (sec2_d[k]),
            .out_v (sec2_v[k+1]),
            .out_d (sec2_d[k+1])
        );
    end

    // final select into the output queue
    cau_pkg::result_t fin;
    logic [W-1:0]     root_im;
    logic             push, pop;

    always_comb
    begin
        fin     = sec2_d[RS].res;
        root_im = sec2_d[RS].ri[W-1:0];
        if (sec2_d[RS].op == cau_pkg::OP_SQRT)
        begin
            fin.res_re    = sec2_d[RS].rr[W-1:0];
            fin.res_im    = sec2_d[RS].ai_neg ? -root_im : root_im;
            fin.div_zero  = 1'b0;
            fin.saturated = 1'b0;
            fin.is_equal  = 1'b0;
        end
    end

    assign push = adv && sec2_v[RS];
    assign pop  = results.valid && results.ready;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= fin;
        end
    end

    assign results.valid     = (count_reg != 2'd0);
    assign results.res_re    = fifo_mem_reg[rd_ptr_reg].res_re;
    assign results.res_im    = fifo_mem_reg[rd_ptr_reg].res_im;
    assign results.div_zero  = fifo_mem_reg[rd_ptr_reg].div_zero;
    assign results.saturated = fifo_mem_reg[rd_ptr_reg].saturated;
    assign results.is_equal  = fifo_mem_reg[rd_ptr_reg].is_equal;

endmodule

FILE: tb/complex_arithmetic_unit_core_tb.sv
// self-checking testbench for the complex alu: random and directed operand words
// depends on cau_pkg, cau_in_if, cau_out_if and complex_arithmetic_unit_core
`timescale 1ns / 100ps

module complex_arithmetic_unit_core_tb;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_WORDS  = 700;
    localparam int DRAIN_WAIT  = 120;

    typedef struct {
        cau_pkg::op_t op;
        logic [31:0]  ar;
        logic [31:0]  ai;
        logic [31:0]  br;
        logic [31:0]  bi;
    } operand_word_t;

    logic clk;
    logic rst_n;

    cau_in_if  operands_if ();
    cau_out_if results_if ();

    complex_arithmetic_unit_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands_if),
        .results  (results_if)
    );

    operand_word_t    pending_q[$];
    cau_pkg::result_t expected_q[$];
    int               words_sent;
    int               mismatches;
    int               cycles;
    int               sender_idle_pct;
    int               receiver_idle_pct;

    // clamp a wide signed value to a 32-bit word
    function automatic logic [31:0] clamp_word(input logic signed [127:0] v,
                                               inout logic sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0]  r;
        logic [127:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= x)
                r = t[63:0];
        end
        return r;
    endfunction

    function automatic cau_pkg::result_t complex_result(input operand_word_t w);
        logic signed [31:0]  ar, ai, br, bi;
        logic signed [127:0] x, y, den, num, mag, q;
        logic [63:0]         m, rr, ri;
        logic                sat;
        cau_pkg::result_t    r;
        ar = w.ar;
        ai = w.ai;
        br = w.br;
        bi = w.bi;
        sat = 1'b0;
        r = '0;
        case (w.op)
            cau_pkg::OP_ADD:
            begin
                x = ar; y = br; r.res_re = clamp_word(x + y, sat);
                x = ai; y = bi; r.res_im = clamp_word(x + y, sat);
            end
            cau_pkg::OP_SUB:
            begin
                x = ar; y = br; r.res_re = clamp_word(x - y, sat);
                x = ai; y = bi; r.res_im = clamp_word(x - y, sat);
            end
            cau_pkg::OP_MUL:
            begin
                x = ar * br - ai * bi + 128'sd32768;
                r.res_re = clamp_word(x >>> cau_pkg::FRAC_BITS, sat);
                x = ar * bi + ai * br + 128'sd32768;
                r.res_im = clamp_word(x >>> cau_pkg::FRAC_BITS, sat);
            end
            cau_pkg::OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.div_zero = 1'b1;
                else
                begin
                    num = ar * br + ai * bi;
                    mag = num < 0 ? -num : num;
                    q = ((mag <<< cau_pkg::FRAC_BITS) + (den >>> 1)) / den;
                    r.res_re = clamp_word(num < 0 ? -q : q, sat);
                    num = ai * br - ar * bi;
                    mag = num < 0 ? -num : num;
                    q = ((mag <<< cau_pkg::FRAC_BITS) + (den >>> 1)) / den;
                    r.res_im = clamp_word(num < 0 ? -q : q, sat);
                end
            end
            cau_pkg::OP_CONJ:
            begin
                x = ar; r.res_re = clamp_word(x, sat);
                x = ai; r.res_im = clamp_word(-x, sat);
            end
            cau_pkg::OP_MAG:
            begin
                x = ar * ar + ai * ai;
                m = floor_sqrt(x[63:0]);
                r.res_re = clamp_word({64'd0, m}, sat);
            end
            cau_pkg::OP_SQRT:
            begin
                x = ar * ar + ai * ai;
                m = floor_sqrt(x[63:0]);
                x = ar;
                y = (x + $signed({64'd0, m})) <<< (cau_pkg::FRAC_BITS - 1);
                rr = floor_sqrt(y[63:0]);
                y = ($signed({64'd0, m}) - x) <<< (cau_pkg::FRAC_BITS - 1);
                ri = floor_sqrt(y[63:0]);
                r.res_re = clamp_word({64'd0, rr}, sat);
                y = {64'd0, ri};
                r.res_im = clamp_word(ai < 0 ? -y : y, sat);
            end
            default:
                r.is_equal = (ar == br) && (ai == bi);
        endcase
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            2:
                case ($urandom_range(0, 4))
                    0: return 32'h80000000;
                    1: return 32'h7fffffff;
                    2: return 32'h0;
                    3: return 32'hffffffff;
                    default: return 32'h00010000;
                endcase
            3: return $urandom >> $urandom_range(0, 31);
            default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    function automatic operand_word_t make_word(input cau_pkg::op_t op,
        input logic [31:0] ar, input logic [31:0] ai,
        input logic [31:0] br, input logic [31:0] bi);
        operand_word_t w;
        w.op = op; w.ar = ar; w.ai = ai; w.br = br; w.bi = bi;
        return w;
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        operands_if.valid = 1'b0;
        operands_if.op = '0;
        operands_if.a_re = '0;
        operands_if.a_im = '0;
        operands_if.b_re = '0;
        operands_if.b_im = '0;
        results_if.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // idling profile follows how far the stimulus has got
    always_comb
    begin
        if (words_sent < 250)
        begin
            sender_idle_pct = 25;
            receiver_idle_pct = 83;
        end
        else if (words_sent < 500)
        begin
            sender_idle_pct = 83;
            receiver_idle_pct = 25;
        end
        else
        begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
        end
    end

    // operand driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operands_if.valid <= 1'b0;
            words_sent <= 0;
        end
        else
        begin
            if (operands_if.valid && operands_if.ready)
            begin
                expected_q.push_back(complex_result(make_word(
                    cau_pkg::op_t'(operands_if.op),
                    operands_if.a_re, operands_if.a_im,
                    operands_if.b_re, operands_if.b_im)));
                void'(pending_q.pop_front());
                words_sent <= words_sent + 1;
            end
            // a word on offer stays until taken
            if (!(operands_if.valid && !operands_if.ready))
            begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    operands_if.valid <= 1'b1;
                    operands_if.op <= pending_q[0].op;
                    operands_if.a_re <= pending_q[0].ar;
                    operands_if.a_im <= pending_q[0].ai;
                    operands_if.b_re <= pending_q[0].br;
                    operands_if.b_im <= pending_q[0].bi;
                end
                else
                    operands_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        cau_pkg::result_t want;
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
            mismatches <= 0;
        end
        else
        begin
            results_if.ready <= $urandom_range(0, 99) >= receiver_idle_pct;
            if (results_if.valid && results_if.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result word re=%h im=%h",
                                 results_if.res_re, results_if.res_im);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (results_if.res_re !== want.res_re
                        || results_if.res_im !== want.res_im
                        || results_if.div_zero !== want.div_zero
                        || results_if.saturated !== want.saturated
                        || results_if.is_equal !== want.is_equal)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: want %h %h %b%b%b got %h %h %b%b%b",
                                     want.res_re, want.res_im, want.div_zero,
                                     want.saturated, want.is_equal,
                                     results_if.res_re, results_if.res_im,
                                     results_if.div_zero, results_if.saturated,
                                     results_if.is_equal);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("complex_arithmetic_unit_core_tb: errors");
            $finish;
        end
    end

    initial
    begin
        operand_word_t w;
        cycles = 0;
        // extremes and special cases
        pending_q.push_back(make_word(cau_pkg::OP_ADD, 32'h7fffffff, 32'h80000000,
                                      32'h1, 32'hffffffff));
        pending_q.push_back(make_word(cau_pkg::OP_SUB, 32'h80000000, 32'h7fffffff,
                                      32'h1, 32'hffffffff));
        pending_q.push_back(make_word(cau_pkg::OP_ADD, 32'h00010000, 32'h00020000,
                                      32'h0, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_MUL, 32'h7fffffff, 32'h7fffffff,
                                      32'h7fffffff, 32'h80000000));
        pending_q.push_back(make_word(cau_pkg::OP_MUL, 32'h00018000, 32'hffff8000,
                                      32'h00008000, 32'h1));
        pending_q.push_back(make_word(cau_pkg::OP_MUL, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h80000000));
        pending_q.push_back(make_word(cau_pkg::OP_DIV, 32'h00010000, 32'h00020000,
                                      32'h0, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_DIV, 32'h00030000, 32'hfffe0000,
                                      32'h00010000, 32'h00010000));
        pending_q.push_back(make_word(cau_pkg::OP_DIV, 32'h7fffffff, 32'h80000000,
                                      32'h1, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_DIV, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h80000000));
        pending_q.push_back(make_word(cau_pkg::OP_CONJ, 32'h12345678, 32'h80000000,
                                      32'h0, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_CONJ, 32'h80000000, 32'h7fffffff,
                                      32'h0, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_MAG, 32'h80000000, 32'h80000000,
                                      32'h0, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_MAG, 32'h00030000, 32'hfffc0000,
                                      32'h0, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_SQRT, 32'hfffc0000, 32'h0,
                                      32'h0, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_SQRT, 32'h00030000, 32'hfffc0000,
                                      32'h0, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_SQRT, 32'h80000000, 32'h80000000,
                                      32'h0, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_SQRT, 32'h7fffffff, 32'h7fffffff,
                                      32'h0, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_SQRT, 32'h0, 32'h0, 32'h0, 32'h0));
        pending_q.push_back(make_word(cau_pkg::OP_EQ, 32'h80000000, 32'h7fffffff,
                                      32'h80000000, 32'h7fffffff));
        pending_q.push_back(make_word(cau_pkg::OP_EQ, 32'h80000000, 32'h7fffffff,
                                      32'h80000000, 32'h7ffffffe));
        pending_q.push_back(make_word(cau_pkg::OP_EQ, 32'hffffffff, 32'hffffffff,
                                      32'hffffffff, 32'hffffffff));
        // sender holds off until the pipeline has drained
        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (5) @(posedge clk);
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            w = make_word(cau_pkg::op_t'($urandom_range(0, 7)), pick_word(), pick_word(),
                          pick_word(), pick_word());
            if (w.op == cau_pkg::OP_EQ && $urandom_range(0, 1) == 1)
            begin
                w.br = w.ar;
                w.bi = w.ai;
            end
            if (w.op == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0)
            begin
                w.br = '0;
                w.bi = '0;
            end
            pending_q.push_back(w);
        end
        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("complex_arithmetic_unit_core_tb: clean");
        else
            $display("complex_arithmetic_unit_core_tb: errors");
        $finish;
    end

endmodule
